>>> hdl/wtt_pkg.sv
// wtt_pkg: shared types, widths and constants for the winograd input tile transform
// no dependencies; imported by winograd_input_tile_transform, wtt_checker and the testbench
`timescale 1ns / 1ps
`default_nettype none

package wtt_pkg;

   // default parameter values
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int MAX_PLANES_DEF  = 1024;

   // fixed field widths
   localparam int VALUE_W = 18;
   localparam int PLANE_W = 10;
   localparam int CNT_W   = 11;
   localparam int COORD_W = 2;
   localparam int POS_W   = 6;
   localparam int ADDR_W  = 6;

   localparam int VALUE_MAX = 131071;
   localparam int VALUE_MIN = -131072;

   // sample positions that complete a tile row
   localparam logic [POS_W-1:0] POS_TROW0 = 6'd23;
   localparam logic [POS_W-1:0] POS_TROW1 = 6'd39;
   localparam logic [POS_W-1:0] POS_TROW2 = 6'd55;
   localparam logic [POS_W-1:0] POS_TROW3 = 6'd63;

   localparam logic [COORD_W-1:0] COORD_LAST = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_FLUSH,
      ST_EMIT
   } wtt_state_type;

   // row pass of transpose(B)*x: t[i] = x[a] op x[b]
   function automatic logic [COORD_W-1:0] row_a(input logic [COORD_W-1:0] i);
      logic [COORD_W-1:0] r;
      unique case (i)
         2'd0:    r = 2'd0;
         2'd1:    r = 2'd1;
         2'd2:    r = 2'd2;
         default: r = 2'd1;
      endcase
      return r;
   endfunction

   function automatic logic [COORD_W-1:0] row_b(input logic [COORD_W-1:0] i);
      logic [COORD_W-1:0] r;
      unique case (i)
         2'd0:    r = 2'd2;
         2'd1:    r = 2'd2;
         2'd2:    r = 2'd1;
         default: r = 2'd3;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hdl/winograd_input_tile_transform.sv
// winograd_input_tile_transform: F(2x2,3x3) input transform over 8x8 planes
// holds the plane store, burst sequencer and one shared add/sub unit; uses wtt_pkg
`timescale 1ns / 1ps
`default_nettype none

// usage
//  - req channel: one plane sample per word, row-major, 64 words per plane
//  - rsp channel: transformed tile elements with plane/tile/element coordinates
//  - csr port: write csr_wr_en with csr_wr_data to set channel_count (planes
//    per layer); write only while no burst is running
//  - words at sample positions 23, 39, 55 and 63 close tile rows 0..3 and
//    start a burst of 64 result words (4 tiles x 16 elements), last marked
//  - other words are only stored and produce no result
//  - a burst streams each element row of each tile through the shared
//    add/sub unit: 8 plane store reads (one read port, registered data)
//    build the row pass in the fetch and flush states, then the emit
//    state gives the column pass, four result words per element row
//  - the closing word starts the fetch, flush and emit states in turn
//  - req_ready is low for the whole burst
//  - the rsp output register holds its word while rsp_ready is low and the
//    sequencer waits; the next request word is taken while the final result
//    of a burst still waits
//  - reset clears position, plane counter, sequencer and output valid and
//    sets channel_count to 1; the plane store is not cleared
module winograd_input_tile_transform #(
   parameter int SAMPLE_BITS = wtt_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_PLANES  = wtt_pkg::MAX_PLANES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0]     req_sample,

   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [wtt_pkg::VALUE_W-1:0]     rsp_value,
   output logic        [wtt_pkg::PLANE_W-1:0]     rsp_plane_index,
   output logic        [wtt_pkg::COORD_W-1:0]     rsp_tile_row,
   output logic        [wtt_pkg::COORD_W-1:0]     rsp_tile_col,
   output logic        [wtt_pkg::COORD_W-1:0]     rsp_elem_row,
   output logic        [wtt_pkg::COORD_W-1:0]     rsp_elem_col,
   output logic                                   rsp_last,

   input  wire logic                              csr_wr_en,
   input  wire logic   [wtt_pkg::CNT_W-1:0]       csr_wr_data
);
   import wtt_pkg::*;

   // row pass needs one extra bit, column pass another
   localparam int ACC_W = SAMPLE_BITS + 2;

   // plane store and its registered read port
   logic signed [SAMPLE_BITS-1:0] plane_store_ff [64];
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic                          rd_zero_ff;
   logic        [ADDR_W-1:0]      rd_addr;
   logic                          rd_inside;

   // input side state
   logic [POS_W-1:0]   pos_ff;
   logic [PLANE_W-1:0] plane_cnt_ff;
   logic [CNT_W-1:0]   chan_count_ff;
   logic [CNT_W-1:0]   plane_next;

   // sequencer
   wtt_state_type      state_ff, state_in;
   logic [COORD_W-1:0] trow_ff, trow_in;
   logic [COORD_W-1:0] tc_ff;
   logic [COORD_W-1:0] i_ff;
   logic [COORD_W-1:0] j_ff;
   logic [2:0]         step_ff;
   logic [PLANE_W-1:0] burst_plane_ff;
   logic               req_fire;
   logic               burst_start;
   logic               issue_rd;
   logic               emit_fire;

   // read pipeline tags
   logic               pend_valid_ff;
   logic               pend_b_ff;
   logic [COORD_W-1:0] pend_j_ff;

   // shared add/sub unit and its operand registers
   logic signed [SAMPLE_BITS-1:0] opa_ff;
   logic signed [ACC_W-1:0]       t0_ff, t1_ff, t2_ff, t3_ff;
   logic signed [ACC_W-1:0]       add_a, add_b, add_sum;
   logic                          add_sub;
   logic signed [SAMPLE_BITS-1:0] x_cur;
   logic signed [VALUE_W-1:0]     sat_value;

   // address generation
   logic [COORD_W-1:0] row_sel;
   logic [COORD_W-1:0] step_j;
   logic [3:0]         r_ext, c_ext;
   logic [2:0]         r_idx, c_idx;

   // output register
   logic                      rsp_valid_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic [PLANE_W-1:0]        rsp_plane_ff;
   logic [COORD_W-1:0]        rsp_trow_ff, rsp_tcol_ff, rsp_erow_ff, rsp_ecol_ff;
   logic                      rsp_last_ff;

   assign req_fire = req_valid && req_ready;

   // tile row closed by this word, if any
   always_comb begin
      burst_start = 1'b0;
      trow_in     = trow_ff;
      unique case (pos_ff)
         POS_TROW0: begin burst_start = 1'b1; trow_in = 2'd0; end
         POS_TROW1: begin burst_start = 1'b1; trow_in = 2'd1; end
         POS_TROW2: begin burst_start = 1'b1; trow_in = 2'd2; end
         POS_TROW3: begin burst_start = 1'b1; trow_in = 2'd3; end
         default: ;
      endcase
   end

   // plane counter wraps at channel_count or at the plane limit
   assign plane_next = CNT_W'(plane_cnt_ff) + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         plane_cnt_ff  <= '0;
         chan_count_ff <= CNT_W'(1);
      end else begin
         if (csr_wr_en) begin
            chan_count_ff <= csr_wr_data;
         end
         if (req_fire) begin
            pos_ff <= pos_ff + 1'b1;
            if (pos_ff == POS_TROW3) begin
               if (plane_next >= chan_count_ff || 32'(plane_next) >= 32'(MAX_PLANES)) begin
                  plane_cnt_ff <= '0;
               end else begin
                  plane_cnt_ff <= plane_next[PLANE_W-1:0];
               end
            end
         end
      end
   end

   // plane store: write on accepted word, one registered read
   always_ff @(posedge clock) begin
      if (req_fire) begin
         plane_store_ff[pos_ff] <= req_sample;
      end
      rd_data_ff <= plane_store_ff[rd_addr];
      rd_zero_ff <= !rd_inside;
   end

   // window position: row 2*trow-1+sel, column 2*tc-1+j, zero outside the plane
   assign step_j  = step_ff[2:1];
   assign row_sel = step_ff[0] ? row_b(i_ff) : row_a(i_ff);
   assign r_ext   = {1'b0, trow_ff, 1'b0} + {2'b00, row_sel};
   assign c_ext   = {1'b0, tc_ff, 1'b0} + {2'b00, step_j};
   assign r_idx   = 3'(r_ext - 4'd1);
   assign c_idx   = 3'(c_ext - 4'd1);
   assign rd_addr = {r_idx, c_idx};
   assign rd_inside = (r_ext != 4'd0) && (r_ext <= 4'd8) &&
                      (c_ext != 4'd0) && (c_ext <= 4'd8);

   assign x_cur = rd_zero_ff ? '0 : rd_data_ff;

   // shared add/sub: row pass while fetching and flushing, column pass while emitting
   always_comb begin
      if (state_ff == ST_EMIT) begin
         add_sub = (j_ff != 2'd1);
         case (j_ff)
            2'd0:    begin add_a = t0_ff; add_b = t2_ff; end
            2'd1:    begin add_a = t1_ff; add_b = t2_ff; end
            2'd2:    begin add_a = t2_ff; add_b = t1_ff; end
            default: begin add_a = t1_ff; add_b = t3_ff; end
         endcase
      end else begin
         // element row 1 is the only sum in the row pass
         add_sub = (i_ff != 2'd1);
         add_a   = ACC_W'(opa_ff);
         add_b   = ACC_W'(x_cur);
      end
      add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);
   end

   generate
      if (ACC_W > VALUE_W) begin : g_sat
         localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(VALUE_MAX);
         localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(VALUE_MIN);
         always_comb begin
            if (add_sum > SAT_HI) begin
               sat_value = VALUE_W'(SAT_HI);
            end else if (add_sum < SAT_LO) begin
               sat_value = VALUE_W'(SAT_LO);
            end else begin
               sat_value = VALUE_W'(add_sum);
            end
         end
      end else begin : g_ext
         assign sat_value = VALUE_W'(add_sum);
      end
   endgenerate

   // sequencer
   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      issue_rd    = 1'b0;
      emit_fire   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && burst_start) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            issue_rd = 1'b1;
            if (step_ff == 3'd7) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            emit_fire = !rsp_valid_ff || rsp_ready;
            if (emit_fire && j_ff == COORD_LAST) begin
               if (i_ff == COORD_LAST && tc_ff == COORD_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tc_ff         <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
         step_ff       <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= issue_rd;
         if (req_fire && burst_start) begin
            tc_ff   <= '0;
            i_ff    <= '0;
            j_ff    <= '0;
            step_ff <= '0;
         end
         if (issue_rd) begin
            step_ff <= step_ff + 1'b1;
         end
         if (emit_fire) begin
            j_ff <= j_ff + 1'b1;
            if (j_ff == COORD_LAST) begin
               i_ff <= i_ff + 1'b1;
               if (i_ff == COORD_LAST) begin
                  tc_ff <= tc_ff + 1'b1;
               end
            end
         end
      end
   end

   // burst coordinates and read tags
   always_ff @(posedge clock) begin
      if (req_fire && burst_start) begin
         trow_ff        <= trow_in;
         burst_plane_ff <= plane_cnt_ff;
      end
      pend_b_ff <= step_ff[0];
      pend_j_ff <= step_j;
   end

   // row pass: first read of a pair is held, second completes t[j]
   always_ff @(posedge clock) begin
      if (pend_valid_ff) begin
         if (!pend_b_ff) begin
            opa_ff <= x_cur;
         end else begin
            case (pend_j_ff)
               2'd0:    t0_ff <= add_sum;
               2'd1:    t1_ff <= add_sum;
               2'd2:    t2_ff <= add_sum;
               default: t3_ff <= add_sum;
            endcase
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_value_ff <= sat_value;
         rsp_plane_ff <= burst_plane_ff;
         rsp_trow_ff  <= trow_ff;
         rsp_tcol_ff  <= tc_ff;
         rsp_erow_ff  <= i_ff;
         rsp_ecol_ff  <= j_ff;
         rsp_last_ff  <= (tc_ff == COORD_LAST) && (i_ff == COORD_LAST) &&
                         (j_ff == COORD_LAST);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_plane_index = rsp_plane_ff;
   assign rsp_tile_row    = rsp_trow_ff;
   assign rsp_tile_col    = rsp_tcol_ff;
   assign rsp_elem_row    = rsp_erow_ff;
   assign rsp_elem_col    = rsp_ecol_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

`default_nettype wire

>>> hdl/wtt_checker.sv
// wtt_checker: port-level assertions for winograd_input_tile_transform
// uses wtt_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps
`default_nettype none

module wtt_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_ready,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic signed [wtt_pkg::VALUE_W-1:0] rsp_value,
   input wire logic        [wtt_pkg::COORD_W-1:0] rsp_tile_col,
   input wire logic        [wtt_pkg::COORD_W-1:0] rsp_elem_row,
   input wire logic        [wtt_pkg::COORD_W-1:0] rsp_elem_col,
   input wire logic                              rsp_last
);
   import wtt_pkg::*;

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_last))
      else $error("rsp word changed under stall");

   // last word sits at the final element of the final tile
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_tile_col == COORD_LAST &&
         rsp_elem_row == COORD_LAST && rsp_elem_col == COORD_LAST)
      else $error("last flag on wrong element");

   // no input taken while a result word other than the last is still valid
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("req ready during burst");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind winograd_input_tile_transform wtt_checker u_wtt_checker (.*);

`default_nettype wire

>>> dv/winograd_input_tile_transform_tb.sv
// winograd_input_tile_transform_tb: self-checking bench for the winograd input tile transform
// streams 8x8 planes under random flow control and checks every result word against
// an in-bench prediction; depends on wtt_pkg and winograd_input_tile_transform
`timescale 1ns / 1ps

module winograd_input_tile_transform_tb;
   import wtt_pkg::*;

   localparam int SAMPLE_W = SAMPLE_BITS_DEF;
   localparam int SETTLE_CYCLES = 40;   // settle time once every result is back
   localparam int REPORT_LIMIT = 10;

   // one transformed tile element with its coordinates
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic        [PLANE_W-1:0] plane;
      logic        [COORD_W-1:0] tile_row;
      logic        [COORD_W-1:0] tile_col;
      logic        [COORD_W-1:0] elem_row;
      logic        [COORD_W-1:0] elem_col;
      logic                      last;
   } tile_word_type;

   // receiver stall patterns
   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_COIN,
      RX_MOSTLY,
      RX_SPARSE
   } rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample = '0;

   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [VALUE_W-1:0]  rsp_value;
   logic        [PLANE_W-1:0]  rsp_plane_index;
   logic        [COORD_W-1:0]  rsp_tile_row;
   logic        [COORD_W-1:0]  rsp_tile_col;
   logic        [COORD_W-1:0]  rsp_elem_row;
   logic        [COORD_W-1:0]  rsp_elem_col;
   logic                       rsp_last;

   logic                       csr_wr_en = 1'b0;
   logic        [CNT_W-1:0]    csr_wr_data = '0;

   winograd_input_tile_transform u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_value       (rsp_value),
      .rsp_plane_index (rsp_plane_index),
      .rsp_tile_row    (rsp_tile_row),
      .rsp_tile_col    (rsp_tile_col),
      .rsp_elem_row    (rsp_elem_row),
      .rsp_elem_col    (rsp_elem_col),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // prediction state: a private copy of the plane and its counters
   // ---------------------------------------------------------------
   logic signed [SAMPLE_W-1:0] plane_img [64];
   logic        [POS_W-1:0]    sample_pos = '0;
   logic        [PLANE_W-1:0]  plane_num = '0;
   logic        [CNT_W-1:0]    plane_limit = 11'd1;   // channel_count after reset

   tile_word_type              tile_words_due [$];    // expected results, oldest first
   logic signed [SAMPLE_W-1:0] sample_queue [$];      // words still to be sent
   int                         error_count = 0;
   logic                       word_taken = 1'b0;     // req word accepted at last rising edge

   // zero outside the plane, like the padding of the first and last tiles
   function automatic int plane_at(input int r, input int c);
      if (r < 0 || c < 0 || r > 7 || c > 7) return 0;
      return int'(plane_img[r * 8 + c]);
   endfunction

   // store one sample; when it closes a tile row, queue the 64 transformed elements
   task automatic absorb_sample(input logic signed [SAMPLE_W-1:0] s);
      int x [4][4];
      int t [4][4];
      int v;
      int trow;
      int tc;
      int i;
      int j;
      int n;
      int unsigned next_plane;
      tile_word_type w;
      plane_img[sample_pos] = s;
      case (sample_pos)
         POS_TROW0: trow = 0;
         POS_TROW1: trow = 1;
         POS_TROW2: trow = 2;
         POS_TROW3: trow = 3;
         default:   trow = -1;
      endcase
      n = 0;
      if (trow >= 0) begin
         for (tc = 0; tc < 4; tc++) begin
            for (i = 0; i < 4; i++)
               for (j = 0; j < 4; j++)
                  x[i][j] = plane_at(2 * trow - 1 + i, 2 * tc - 1 + j);
            // row pass: transpose(B) * x
            for (j = 0; j < 4; j++) begin
               t[0][j] = x[0][j] - x[2][j];
               t[1][j] = x[1][j] + x[2][j];
               t[2][j] = x[2][j] - x[1][j];
               t[3][j] = x[1][j] - x[3][j];
            end
            // column pass: (...) * B, one element at a time
            for (i = 0; i < 4; i++) begin
               for (j = 0; j < 4; j++) begin
                  case (j)
                     0:       v = t[i][0] - t[i][2];
                     1:       v = t[i][1] + t[i][2];
                     2:       v = t[i][2] - t[i][1];
                     default: v = t[i][1] - t[i][3];
                  endcase
                  if (v > VALUE_MAX) v = VALUE_MAX;
                  if (v < VALUE_MIN) v = VALUE_MIN;
                  w.value    = v[VALUE_W-1:0];
                  w.plane    = plane_num;
                  w.tile_row = trow[COORD_W-1:0];
                  w.tile_col = tc[COORD_W-1:0];
                  w.elem_row = i[COORD_W-1:0];
                  w.elem_col = j[COORD_W-1:0];
                  w.last     = (n == 63);
                  tile_words_due.push_back(w);
                  n++;
               end
            end
         end
      end
      // plane end: advance the channel, wrapping at the count or the hard limit
      if (sample_pos == POS_TROW3) begin
         next_plane = int'(plane_num) + 1;
         if (next_plane >= plane_limit || next_plane >= MAX_PLANES_DEF) next_plane = 0;
         plane_num = next_plane[PLANE_W-1:0];
      end
      sample_pos = sample_pos + 1'b1;
   endtask

   function automatic string word_text(input tile_word_type w);
      return $sformatf("value=%0d plane=%0d tile=(%0d,%0d) elem=(%0d,%0d) last=%0b",
                       w.value, w.plane, w.tile_row, w.tile_col, w.elem_row, w.elem_col,
                       w.last);
   endfunction

   // ---------------------------------------------------------------
   // monitor: result check first, then prediction of the accepted word
   // ---------------------------------------------------------------
   always @(posedge clock) begin : monitor_blk
      tile_word_type got;
      tile_word_type want;
      if (reset) begin
         word_taken = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.value    = rsp_value;
            got.plane    = rsp_plane_index;
            got.tile_row = rsp_tile_row;
            got.tile_col = rsp_tile_col;
            got.elem_row = rsp_elem_row;
            got.elem_col = rsp_elem_col;
            got.last     = rsp_last;
            if (tile_words_due.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%0t unexpected result word: %s", $realtime, word_text(got));
            end else begin
               want = tile_words_due.pop_front();
               if (got.value !== want.value || got.plane !== want.plane ||
                   got.tile_row !== want.tile_row || got.tile_col !== want.tile_col ||
                   got.elem_row !== want.elem_row || got.elem_col !== want.elem_col ||
                   got.last !== want.last) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT) begin
                     $display("%0t result mismatch", $realtime);
                     $display("   expected %s", word_text(want));
                     $display("   actual   %s", word_text(got));
                  end
               end
            end
         end
         word_taken = req_valid && req_ready;
         if (word_taken) absorb_sample(req_sample);
      end
   end

   // ---------------------------------------------------------------
   // driver: bursts of words with random gaps, fed from sample_queue
   // ---------------------------------------------------------------
   int   burst_left = 8;
   int   gap_left = 0;
   logic drain_hold = 1'b0;   // hold off until every pending result is back

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !word_taken) begin
         // word still offered, keep it steady
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left--;
      end else if (drain_hold && tile_words_due.size() != 0) begin
         req_valid <= 1'b0;
      end else if (sample_queue.size() != 0) begin
         drain_hold = 1'b0;
         req_valid  <= 1'b1;
         req_sample <= sample_queue.pop_front();
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            // some bursts run back to back, others leave short or long gaps
            case ($urandom_range(0, 3))
               0:       gap_left = 0;
               1:       gap_left = $urandom_range(1, 3);
               2:       gap_left = $urandom_range(4, 16);
               default: gap_left = $urandom_range(17, 60);
            endcase
            if ($urandom_range(0, 5) == 0) drain_hold = 1'b1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // receiver: stall pattern redrawn at random, each kept for a random run of cycles
   // ---------------------------------------------------------------
   rx_mode_type rx_mode = RX_ALWAYS;
   int          rx_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rx_left <= 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 96);
         end
         rx_left--;
         case (rx_mode)
            RX_ALWAYS: rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            RX_MOSTLY: rsp_ready <= ($urandom_range(0, 7) != 0);
            default:   rsp_ready <= (rx_left % 8 == 0);   // long stalls
         endcase
      end
   end

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------
   // mostly full-range values, with extremes and near-zero values mixed in
   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 7))
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         2:       return $signed(16'($urandom_range(0, 16))) - 16'sd8;
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   task automatic queue_random_words(input int count);
      int k;
      for (k = 0; k < count; k++) sample_queue.push_back(random_sample());
   endtask

   // everything sent, every result back, and the sequencer given time to settle
   task automatic wait_until_idle();
      while (sample_queue.size() != 0 || req_valid || tile_words_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // channel_count is only written while the block is idle
   task automatic write_channel_count(input logic [CNT_W-1:0] count);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      plane_limit = count;
      @(posedge clock);
   endtask

   task automatic run_phase(input logic [CNT_W-1:0] count, input int words);
      write_channel_count(count);
      queue_random_words(words);
      wait_until_idle();
   endtask

   // ---------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------
   initial begin : main_seq
      int k;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: rows 0..2 at full scale, closes tile row 0 at the 24th word
      // row 0 all max, row 1 all min, row 2 alternating min and max
      for (k = 0; k < 8; k++) sample_queue.push_back(16'sh7fff);
      for (k = 0; k < 8; k++) sample_queue.push_back(16'sh8000);
      for (k = 0; k < 8; k++) sample_queue.push_back(k[0] ? 16'sh7fff : 16'sh8000);
      // rest of the first plane with the reset channel count of one
      queue_random_words(40);
      wait_until_idle();

      // count of zero while words 0..39 of the next plane go in; no plane ends under it
      run_phase(11'd0, 40);
      // oversized count (above the plane limit) ends the plane, plane index steps to 1
      run_phase(11'd2047, 24);
      // three planes per layer, index steps to 2
      run_phase(11'd3, 64);
      // count set at the start of the plane and changed mid-plane; the index is already past the last
      // value, so it wraps to 0 at the end of this plane
      run_phase(11'd1024, 30);
      run_phase(11'd2, 34);
      run_phase(11'd1, 40);
      run_phase(11'd2, 24);

      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #3200000;
      $display("tb: failure");
      $finish;
   end

endmodule
